>>> src/spd_pkg.sv
// Scan packet deframer package: framing constants, result kinds, emitter command.
// Depends on nothing; used by scan_packet_deframer and spd_emitter.
package spd_pkg;

   localparam int PAYLOAD_DEPTH = 256;
   localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
   localparam int GROUP_BYTES   = 6;
   localparam int MAX_LENGTH    = 255;
   localparam int GROUP_W       = $clog2(MAX_LENGTH / GROUP_BYTES + 1);

   localparam logic [7:0] SYNC_A   = 8'd11;
   localparam logic [7:0] SYNC_B   = 8'd22;
   localparam logic [7:0] SYNC_C   = 8'd55;
   localparam logic [7:0] END_BYTE = 8'hB2;

   // mark byte is 1x with units 2..8
   localparam logic [7:0] MARK_BASE = 8'd10;
   localparam logic [7:0] MARK_LO   = 8'd12;
   localparam logic [7:0] MARK_HI   = 8'd18;
   localparam logic [3:0] MARK_ACK  = 4'd2;
   localparam logic [3:0] MARK_SCAN = 4'd3;

   localparam logic [1:0] KIND_POINT = 2'd0;
   localparam logic [1:0] KIND_ACK   = 2'd1;
   localparam logic [1:0] KIND_NACK  = 2'd2;

   typedef struct packed {
      logic               start;
      logic [1:0]         kind;
      logic [GROUP_W-1:0] groups;
   } emit_cmd_type;

   function automatic logic [7:0] sync_byte(input logic [1:0] pos);
      logic [7:0] b;
      unique case (pos)
         2'd1:    b = SYNC_B;
         2'd2:    b = SYNC_C;
         default: b = SYNC_A;
      endcase
      return b;
   endfunction

endpackage

>>> src/spd_if.sv
// Request and response channel interfaces of the scan packet deframer.
// Depends on nothing.
interface spd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface spd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] horizontal_angle;
   logic [15:0] vertical_angle;
   logic [15:0] range_value;
   logic        last_of_run;

   modport source (output valid, output result_kind, output horizontal_angle,
                   output vertical_angle, output range_value, output last_of_run,
                   input ready);
   modport sink   (input valid, input result_kind, input horizontal_angle,
                   input vertical_angle, input range_value, input last_of_run,
                   output ready);
endinterface

>>> src/scan_packet_deframer.sv
// Top level of the scan packet deframer: byte parser, payload store, result sequencer.
// Depends on spd_pkg, spd_if, spd_ram and spd_emitter.
// Header, length, payload and check bytes are taken without a result.
// End byte: request is held off until the run is out; an acknowledge passes through
// the command register, the acknowledge state and the output register, and each group
// of points takes six store reads, one read-latency state and an output load.
// Reset (synchronous, active high) returns to sync hunt; the payload store is not cleared.
module scan_packet_deframer (
   input  logic      clock,
   input  logic      reset,
   spd_req_if.sink   req_port,
   spd_rsp_if.source rsp_port
);

   typedef enum logic [2:0] {
      PH_SYNC,
      PH_MARK,
      PH_LEN,
      PH_DATA,
      PH_CHECK,
      PH_END
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [1:0]                  sync_pos_ff, sync_pos_in;
   logic [3:0]                  mark_ff, mark_in;
   logic [7:0]                  length_ff, length_in;
   logic [7:0]                  count_ff, count_in;
   logic [7:0]                  xor_ff, xor_in;
   logic [2:0]                  grp_byte_ff, grp_byte_in;
   logic [spd_pkg::GROUP_W-1:0] groups_ff, groups_in;
   spd_pkg::emit_cmd_type       cmd_ff, cmd_in;

   logic                        req_fire;
   logic                        emit_busy;
   logic [7:0]                  b;
   logic [1:0]                  pos_eff;
   logic [7:0]                  count_next;
   logic                        wr_en;
   logic                        rd_en;
   logic [spd_pkg::ADDR_W-1:0]  rd_addr;
   logic [7:0]                  rd_data;

   assign b              = req_port.in_byte;
   assign req_port.ready = !emit_busy && !cmd_ff.start;
   assign req_fire       = req_port.valid && req_port.ready;
   assign count_next     = count_ff + 8'd1;

   always_comb begin
      phase_in    = phase_ff;
      sync_pos_in = sync_pos_ff;
      mark_in     = mark_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      xor_in      = xor_ff;
      grp_byte_in = grp_byte_ff;
      groups_in   = groups_ff;
      cmd_in      = '0;
      wr_en       = 1'b0;
      pos_eff     = sync_pos_ff;

      if (req_fire) begin
         unique case (phase_ff)
            PH_SYNC: begin
               // a broken partial match restarts and re-tests this byte
               if (sync_pos_ff >= 2'd3 ||
                   (sync_pos_ff != 2'd0 && b != spd_pkg::sync_byte(sync_pos_ff))) begin
                  pos_eff = 2'd0;
               end
               if (b == spd_pkg::sync_byte(pos_eff)) begin
                  if (pos_eff == 2'd2) begin
                     sync_pos_in = 2'd0;
                     phase_in    = PH_MARK;
                  end else begin
                     sync_pos_in = pos_eff + 2'd1;
                  end
               end else begin
                  sync_pos_in = pos_eff;
               end
            end
            PH_MARK: begin
               if (b >= spd_pkg::MARK_LO && b <= spd_pkg::MARK_HI) begin
                  mark_in  = 4'(b - spd_pkg::MARK_BASE);
                  phase_in = PH_LEN;
               end else begin
                  phase_in = PH_SYNC;
               end
            end
            PH_LEN: begin
               length_in   = b;
               count_in    = 8'd0;
               xor_in      = 8'd0;
               grp_byte_in = 3'd0;
               groups_in   = '0;
               phase_in    = (b == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
               wr_en    = {1'b0, count_ff} < 9'(spd_pkg::PAYLOAD_DEPTH);
               xor_in   = xor_ff ^ b;
               count_in = count_next;
               // complete groups are counted as they arrive
               if (grp_byte_ff == 3'(spd_pkg::GROUP_BYTES - 1)) begin
                  grp_byte_in = 3'd0;
                  groups_in   = groups_ff + spd_pkg::GROUP_W'(1);
               end else begin
                  grp_byte_in = grp_byte_ff + 3'd1;
               end
               if (count_next == length_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               phase_in = (xor_ff == b) ? PH_END : PH_SYNC;
            end
            PH_END: begin
               if (b != spd_pkg::END_BYTE) begin
                  if (mark_ff == spd_pkg::MARK_ACK) begin
                     cmd_in.start = 1'b1;
                     cmd_in.kind  = spd_pkg::KIND_NACK;
                  end
               end else if (mark_ff == spd_pkg::MARK_SCAN) begin
                  cmd_in.start  = groups_ff != '0;
                  cmd_in.kind   = spd_pkg::KIND_POINT;
                  cmd_in.groups = groups_ff;
               end else if (mark_ff == spd_pkg::MARK_ACK) begin
                  cmd_in.start = 1'b1;
                  cmd_in.kind  = spd_pkg::KIND_ACK;
               end
               phase_in = PH_SYNC;
            end
            default: begin
               phase_in = PH_SYNC;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SYNC;
         sync_pos_ff <= 2'd0;
         mark_ff     <= 4'd0;
         length_ff   <= 8'd0;
         count_ff    <= 8'd0;
         xor_ff      <= 8'd0;
         grp_byte_ff <= 3'd0;
         groups_ff   <= '0;
         cmd_ff      <= '0;
      end else begin
         phase_ff    <= phase_in;
         sync_pos_ff <= sync_pos_in;
         mark_ff     <= mark_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
         xor_ff      <= xor_in;
         grp_byte_ff <= grp_byte_in;
         groups_ff   <= groups_in;
         cmd_ff      <= cmd_in;
      end
   end

   spd_ram #(
      .WIDTH (8),
      .DEPTH (spd_pkg::PAYLOAD_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[spd_pkg::ADDR_W-1:0]),
      .wr_data (b),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   spd_emitter u_emitter (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd_ff),
      .busy    (emit_busy),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rsp     (rsp_port)
   );

   a_closed_while_busy : assert property (@(posedge clock) disable iff (reset)
      emit_busy |-> !req_port.ready)
      else $error("request taken while results pending");

   a_data_nonzero_len : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> length_ff != 8'd0 && count_ff < length_ff)
      else $error("payload phase with count past length");

   a_group_tally : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA || phase_ff == PH_CHECK || phase_ff == PH_END
      |-> grp_byte_ff < 3'(spd_pkg::GROUP_BYTES))
      else $error("group byte index out of range");

endmodule

>>> src/spd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module spd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/spd_emitter.sv
// Result sequencer: reads each 6-byte group of stored payload one byte a cycle
// into a point, drives the response output register. Depends on spd_pkg, spd_if.
module spd_emitter (
   input  logic                       clock,
   input  logic                       reset,
   input  spd_pkg::emit_cmd_type      cmd,
   output logic                       busy,
   output logic                       rd_en,
   output logic [spd_pkg::ADDR_W-1:0] rd_addr,
   input  logic [7:0]                 rd_data,
   spd_rsp_if.source                  rsp
);

   typedef enum logic [2:0] {
      E_IDLE,
      E_READ,
      E_DRAIN,
      E_PUSH,
      E_ACK
   } emit_state_type;

   emit_state_type                state_ff, state_in;
   logic [spd_pkg::GROUP_W-1:0]   groups_left_ff, groups_left_in;
   logic [7:0]                    addr_ff, addr_in;
   logic [2:0]                    byte_cnt_ff, byte_cnt_in;
   logic                          cap_ff, cap_in;
   logic                          in_range_ff, in_range_in;
   logic [47:0]                   shift_ff, shift_in;
   logic [1:0]                    ack_kind_ff, ack_kind_in;

   logic                          out_valid_ff, out_valid_in;
   logic [1:0]                    out_kind_ff, out_kind_in;
   logic [15:0]                   out_h_ff, out_h_in;
   logic [15:0]                   out_v_ff, out_v_in;
   logic [15:0]                   out_r_ff, out_r_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_free;
   logic                          addr_ok;

   assign out_free = !out_valid_ff || rsp.ready;
   assign addr_ok  = {1'b0, addr_ff} < 9'(spd_pkg::PAYLOAD_DEPTH);
   assign rd_addr  = addr_ff[spd_pkg::ADDR_W-1:0];
   assign busy     = state_ff != E_IDLE;

   always_comb begin
      state_in       = state_ff;
      groups_left_in = groups_left_ff;
      addr_in        = addr_ff;
      byte_cnt_in    = byte_cnt_ff;
      ack_kind_in    = ack_kind_ff;
      rd_en          = 1'b0;
      out_valid_in   = out_valid_ff && !rsp.ready;
      out_kind_in    = out_kind_ff;
      out_h_in       = out_h_ff;
      out_v_in       = out_v_ff;
      out_r_in       = out_r_ff;
      out_last_in    = out_last_ff;
      shift_in       = shift_ff;

      // bytes beyond the store read back as zero
      if (cap_ff) begin
         shift_in = {shift_ff[39:0], in_range_ff ? rd_data : 8'h00};
      end

      unique case (state_ff)
         E_IDLE: begin
            if (cmd.start) begin
               if (cmd.kind == spd_pkg::KIND_POINT) begin
                  state_in       = E_READ;
                  groups_left_in = cmd.groups;
                  addr_in        = 8'd0;
                  byte_cnt_in    = 3'd0;
               end else begin
                  state_in    = E_ACK;
                  ack_kind_in = cmd.kind;
               end
            end
         end
         E_READ: begin
            rd_en   = addr_ok;
            addr_in = addr_ff + 8'd1;
            if (byte_cnt_ff == 3'(spd_pkg::GROUP_BYTES - 1)) begin
               byte_cnt_in = 3'd0;
               state_in    = E_DRAIN;
            end else begin
               byte_cnt_in = byte_cnt_ff + 3'd1;
            end
         end
         E_DRAIN: begin
            state_in = E_PUSH;
         end
         E_PUSH: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_kind_in    = spd_pkg::KIND_POINT;
               out_h_in       = shift_ff[47:32];
               out_v_in       = shift_ff[31:16];
               out_r_in       = shift_ff[15:0];
               out_last_in    = groups_left_ff == spd_pkg::GROUP_W'(1);
               groups_left_in = groups_left_ff - spd_pkg::GROUP_W'(1);
               state_in       = (groups_left_ff == spd_pkg::GROUP_W'(1)) ? E_IDLE : E_READ;
            end
         end
         E_ACK: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = ack_kind_ff;
               out_h_in     = 16'd0;
               out_v_in     = 16'd0;
               out_r_in     = 16'd0;
               out_last_in  = 1'b1;
               state_in     = E_IDLE;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   assign cap_in      = rd_en || (state_ff == E_READ);
   assign in_range_in = addr_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_IDLE;
         cap_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         out_valid_ff <= out_valid_in;
      end
      groups_left_ff <= groups_left_in;
      addr_ff        <= addr_in;
      byte_cnt_ff    <= byte_cnt_in;
      in_range_ff    <= in_range_in;
      shift_ff       <= shift_in;
      ack_kind_ff    <= ack_kind_in;
      out_kind_ff    <= out_kind_in;
      out_h_ff       <= out_h_in;
      out_v_ff       <= out_v_in;
      out_r_ff       <= out_r_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.result_kind      = out_kind_ff;
   assign rsp.horizontal_angle = out_h_ff;
   assign rsp.vertical_angle   = out_v_ff;
   assign rsp.range_value      = out_r_ff;
   assign rsp.last_of_run      = out_last_ff;

   a_start_when_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == E_IDLE)
      else $error("emit command while sequencer busy");

   a_groups_left : assert property (@(posedge clock) disable iff (reset)
      (state_ff == E_READ || state_ff == E_PUSH) |-> groups_left_ff != '0)
      else $error("group run with no groups left");

   a_group_complete : assert property (@(posedge clock) disable iff (reset)
      state_ff == E_PUSH && $past(state_ff) == E_DRAIN |-> $past(cap_ff))
      else $error("last byte of group not captured");

endmodule
